// File: design/wrcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrcu_pkg
// Shared types, codes and constants of the weighted residue cover engine.
// ----------------------------------------------------------------------------
package wrcu_pkg;

  localparam int RING_MAX_DEF    = 4096;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int OP_W      = 3;
  localparam int MOD_W     = 13;
  localparam int RES_W     = 12;
  localparam int GAIN_W    = 32;
  localparam int TOT_W     = 13;
  localparam int RING_W    = 13;
  localparam int NOISE_W   = 16;
  localparam int SEED_W    = 64;
  localparam int TALLY_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 7;

  localparam int XS_A = 13;
  localparam int XS_B = 7;
  localparam int XS_C = 17;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_REM  = 3'd1;
  localparam logic [OP_W-1:0] OP_BEST = 3'd2;
  localparam logic [OP_W-1:0] OP_BUMP = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

  localparam logic [RING_W-1:0]  RING_RST  = 13'd4096;
  localparam logic [NOISE_W-1:0] NOISE_RST = 16'd9830;
  localparam logic [SEED_W-1:0]  SEED_RST  = 64'd88172645463325252;

  localparam logic [LEN_W-1:0] LEN_WORD = 7'd64;

  typedef struct packed {
    logic [RING_W-1:0]  ring_size;
    logic [NOISE_W-1:0] noise_threshold;
    logic [SEED_W-1:0]  rng_seed;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [MOD_W-1:0] modulus;
    logic [RES_W-1:0] residue;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [RES_W-1:0]  picked_residue;
    logic [GAIN_W-1:0] best_gain;
    logic [TOT_W-1:0]  uncovered_total;
  } res_t;

  function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] x;
    x = s;
    x = x ^ (x << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    return x;
  endfunction

endpackage
`default_nettype wire

// File: design/wrcu_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrcu channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface wrcu_in_if;
  logic                       valid;
  logic                       ready;
  logic [wrcu_pkg::OP_W-1:0]  op;
  logic [wrcu_pkg::MOD_W-1:0] modulus;
  logic [wrcu_pkg::RES_W-1:0] residue;
  modport source (output valid, output op, output modulus, output residue, input ready);
  modport sink (input valid, input op, input modulus, input residue, output ready);
endinterface

interface wrcu_out_if;
  logic                        valid;
  logic                        ready;
  logic [wrcu_pkg::RES_W-1:0]  picked_residue;
  logic [wrcu_pkg::GAIN_W-1:0] best_gain;
  logic [wrcu_pkg::TOT_W-1:0]  uncovered_total;
  modport source (output valid, output picked_residue, output best_gain,
                  output uncovered_total, input ready);
  modport sink (input valid, input picked_residue, input best_gain,
                input uncovered_total, output ready);
endinterface

interface wrcu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wrcu_pkg::CFG_IDX_W-1:0] index;
  logic [wrcu_pkg::SEED_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/wrcu_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrcu_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module wrcu_mod #(
  parameter int DW = 13
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [wrcu_pkg::SEED_W-1:0] dvd,
  input  wire [DW-1:0]               dvs,
  input  wire [wrcu_pkg::LEN_W-1:0]  len,
  output logic                       done,
  output logic [DW-1:0]              rem
);

  localparam logic [wrcu_pkg::LEN_W-1:0] LEN_ONE = 7'd1;

  logic                        busy_r;
  logic                        done_r;
  logic [wrcu_pkg::LEN_W-1:0]  cnt_r;
  logic [wrcu_pkg::SEED_W-1:0] dvd_r;
  logic [DW-1:0]               dvs_r;
  logic [DW-1:0]               rem_r;
  logic [DW:0]                 trial;
  logic [DW-1:0]               rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[wrcu_pkg::SEED_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == LEN_ONE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: design/wrcu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrcu_core
// Operation sequencer around the point, list, weight, score and touched
// memories; read, modify and write back one entry at a time.
// ----------------------------------------------------------------------------
module wrcu_core #(
  parameter int RING_MAX    = wrcu_pkg::RING_MAX_DEF,
  parameter int WEIGHT_BITS = wrcu_pkg::WEIGHT_BITS_DEF,
  parameter int COUNT_BITS  = wrcu_pkg::COUNT_BITS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wrcu_pkg::cfg_t  cfg,
  input  wire             req_valid,
  input  wrcu_pkg::req_t  req,
  output logic            req_ready,
  output wrcu_pkg::res_t  res,
  input  wire             res_ready
);

  localparam int IW = (RING_MAX > 1) ? $clog2(RING_MAX) : 1;
  localparam int SW = IW + 1;
  localparam int JW = ((SW > wrcu_pkg::MOD_W) ? SW : wrcu_pkg::MOD_W) + 1;
  localparam int DW = (SW > wrcu_pkg::MOD_W) ? SW : wrcu_pkg::MOD_W;
  localparam int GW = wrcu_pkg::GAIN_W;

  localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [WEIGHT_BITS-1:0] WT_MAX  = {WEIGHT_BITS{1'b1}};
  localparam logic [WEIGHT_BITS-1:0] WT_ONE  = WEIGHT_BITS'(1);
  localparam logic [SW-1:0] RING_FULL = SW'(RING_MAX);
  localparam logic [SW-1:0] ACTIVE_RST =
      (wrcu_pkg::RING_RST == '0) ? SW'(1) :
      ((32'(wrcu_pkg::RING_RST) > 32'(RING_MAX)) ? RING_FULL : SW'(wrcu_pkg::RING_RST));
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_MAX - 1);

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_CLR  = 6'd1;
  localparam logic [5:0] S_A0   = 6'd2;
  localparam logic [5:0] S_A1   = 6'd3;
  localparam logic [5:0] S_A2   = 6'd4;
  localparam logic [5:0] S_R0   = 6'd5;
  localparam logic [5:0] S_R1   = 6'd6;
  localparam logic [5:0] S_B0   = 6'd7;
  localparam logic [5:0] S_B1   = 6'd8;
  localparam logic [5:0] S_B2   = 6'd9;
  localparam logic [5:0] S_B3   = 6'd10;
  localparam logic [5:0] S_B4   = 6'd11;
  localparam logic [5:0] S_P    = 6'd12;
  localparam logic [5:0] S_BZ   = 6'd13;
  localparam logic [5:0] S_N0   = 6'd14;
  localparam logic [5:0] S_N1   = 6'd15;
  localparam logic [5:0] S_N2   = 6'd16;
  localparam logic [5:0] S_N3   = 6'd17;
  localparam logic [5:0] S_N4   = 6'd18;
  localparam logic [5:0] S_N5   = 6'd19;
  localparam logic [5:0] S_T0   = 6'd20;
  localparam logic [5:0] S_T1   = 6'd21;
  localparam logic [5:0] S_T2   = 6'd22;
  localparam logic [5:0] S_T3   = 6'd23;
  localparam logic [5:0] S_T4   = 6'd24;
  localparam logic [5:0] S_T5   = 6'd25;
  localparam logic [5:0] S_T6   = 6'd26;
  localparam logic [5:0] S_T7   = 6'd27;
  localparam logic [5:0] S_T8   = 6'd28;
  localparam logic [5:0] S_K0   = 6'd29;
  localparam logic [5:0] S_K1   = 6'd30;
  localparam logic [5:0] S_W0   = 6'd31;
  localparam logic [5:0] S_W1   = 6'd32;
  localparam logic [5:0] S_W2   = 6'd33;
  localparam logic [5:0] S_W3   = 6'd34;
  localparam logic [5:0] S_W4   = 6'd35;
  localparam logic [5:0] S_H0   = 6'd36;
  localparam logic [5:0] S_H1   = 6'd37;
  localparam logic [5:0] S_DONE = 6'd38;

  // memories
  logic [COUNT_BITS-1:0]  cc_mem  [RING_MAX];
  logic [IW-1:0]          lst_mem [RING_MAX];
  logic [SW-1:0]          slt_mem [RING_MAX];
  logic [WEIGHT_BITS-1:0] wt_mem  [RING_MAX];
  logic [GW-1:0]          sc_mem  [RING_MAX];
  logic [IW-1:0]          tch_mem [RING_MAX];

  logic [COUNT_BITS-1:0]  cc_rd, cc_wd;
  logic [IW-1:0]          lst_rd, lst_wd;
  logic [SW-1:0]          slt_rd, slt_wd;
  logic [WEIGHT_BITS-1:0] wt_rd, wt_wd;
  logic [GW-1:0]          sc_rd, sc_wd;
  logic [IW-1:0]          tch_rd, tch_wd;
  logic [IW-1:0] cc_ra, lst_ra, slt_ra, wt_ra, sc_ra, tch_ra;
  logic [IW-1:0] cc_wa, lst_wa, slt_wa, wt_wa, sc_wa, tch_wa;
  logic cc_we, lst_we, slt_we, wt_we, sc_we, tch_we;

  always_ff @(posedge clk) begin
    if (cc_we) cc_mem[cc_wa] <= cc_wd;
    cc_rd <= cc_mem[cc_ra];
  end
  always_ff @(posedge clk) begin
    if (lst_we) lst_mem[lst_wa] <= lst_wd;
    lst_rd <= lst_mem[lst_ra];
  end
  always_ff @(posedge clk) begin
    if (slt_we) slt_mem[slt_wa] <= slt_wd;
    slt_rd <= slt_mem[slt_ra];
  end
  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd <= wt_mem[wt_ra];
  end
  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_wa] <= sc_wd;
    sc_rd <= sc_mem[sc_ra];
  end
  always_ff @(posedge clk) begin
    if (tch_we) tch_mem[tch_wa] <= tch_wd;
    tch_rd <= tch_mem[tch_ra];
  end

  // registers
  logic [5:0]                   st_r, st_nxt;
  logic                         init_r, init_nxt;
  logic [JW-1:0]                j_r, j_nxt;
  logic [SW-1:0]                size_r, size_nxt;
  logic [SW-1:0]                active_r, active_nxt;
  logic [wrcu_pkg::SEED_W-1:0]  rng_r, rng_nxt;
  logic [wrcu_pkg::TALLY_W-1:0] tally_r, tally_nxt;
  logic [SW-1:0]                i_r, i_nxt;
  logic [SW-1:0]                nt_r, nt_nxt;
  logic [SW-1:0]                ties_r, ties_nxt;
  logic [wrcu_pkg::MOD_W-1:0]   m_r, m_nxt;
  logic [SW-1:0]                p_r, p_nxt;
  logic [IW-1:0]                u_r, u_nxt;
  logic [IW-1:0]                c_r, c_nxt;
  logic [IW-1:0]                pick_r, pick_nxt;
  logic [GW-1:0]                bg_r, bg_nxt;
  logic [GW-1:0]                gain_r, gain_nxt;
  logic [wrcu_pkg::RES_W-1:0]   picked_r, picked_nxt;

  logic                        mod_start, mod_done;
  logic [wrcu_pkg::SEED_W-1:0] mod_dvd;
  logic [DW-1:0]               mod_div, mod_rem;
  logic [wrcu_pkg::LEN_W-1:0]  mod_len;

  wrcu_mod #(.DW(DW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .dvd   (mod_dvd),
    .dvs   (mod_div),
    .len   (mod_len),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  logic [SW-1:0]               clamp_n;
  logic [SW-1:0]               size_m1;
  logic [SW-1:0]               ties_inc;
  logic [JW-1:0]               j_step;
  logic [GW:0]                 sum;
  logic [wrcu_pkg::SEED_W-1:0] draw;

  always_comb begin
    if (cfg.ring_size == '0) begin
      clamp_n = SW'(1);
    end else if (32'(cfg.ring_size) > 32'(RING_MAX)) begin
      clamp_n = RING_FULL;
    end else begin
      clamp_n = SW'(cfg.ring_size);
    end
    size_m1  = size_r - 1'b1;
    ties_inc = ties_r + 1'b1;
    j_step   = j_r + JW'(m_r);
    sum      = {1'b0, sc_rd} + (GW + 1)'(wt_rd);
    draw     = wrcu_pkg::xorshift(rng_r);
  end

  always_comb begin
    st_nxt     = st_r;
    init_nxt   = init_r;
    j_nxt      = j_r;
    size_nxt   = size_r;
    active_nxt = active_r;
    rng_nxt    = rng_r;
    tally_nxt  = tally_r;
    i_nxt      = i_r;
    nt_nxt     = nt_r;
    ties_nxt   = ties_r;
    m_nxt      = m_r;
    p_nxt      = p_r;
    u_nxt      = u_r;
    c_nxt      = c_r;
    pick_nxt   = pick_r;
    bg_nxt     = bg_r;
    gain_nxt   = gain_r;
    picked_nxt = picked_r;

    cc_ra  = j_r[IW-1:0];
    slt_ra = j_r[IW-1:0];
    lst_ra = i_r[IW-1:0];
    wt_ra  = u_r;
    sc_ra  = c_r;
    tch_ra = i_r[IW-1:0];
    cc_we  = 1'b0; cc_wa  = j_r[IW-1:0]; cc_wd  = '0;
    lst_we = 1'b0; lst_wa = j_r[IW-1:0]; lst_wd = j_r[IW-1:0];
    slt_we = 1'b0; slt_wa = j_r[IW-1:0]; slt_wd = SW'(j_r[IW-1:0]);
    wt_we  = 1'b0; wt_wa  = j_r[IW-1:0]; wt_wd  = WT_ONE;
    sc_we  = 1'b0; sc_wa  = j_r[IW-1:0]; sc_wd  = '0;
    tch_we = 1'b0; tch_wa = nt_r[IW-1:0]; tch_wd = c_r;

    mod_start = 1'b0;
    mod_dvd   = draw;
    mod_div   = DW'(m_r);
    mod_len   = wrcu_pkg::LEN_WORD;

    req_ready = (st_r == S_IDLE);
    res.valid           = (st_r == S_DONE);
    res.picked_residue  = picked_r;
    res.best_gain       = gain_r;
    res.uncovered_total = wrcu_pkg::TOT_W'(size_r);

    case (st_r)
      S_IDLE: begin
        if (req_valid) begin
          m_nxt      = req.modulus;
          j_nxt      = JW'(req.residue);
          i_nxt      = '0;
          nt_nxt     = '0;
          picked_nxt = '0;
          gain_nxt   = '0;
          case (req.op)
            wrcu_pkg::OP_ADD:  st_nxt = (req.modulus == '0) ? S_DONE : S_A0;
            wrcu_pkg::OP_REM:  st_nxt = (req.modulus == '0) ? S_DONE : S_R0;
            wrcu_pkg::OP_BEST: st_nxt = (req.modulus == '0) ? S_DONE : S_B0;
            wrcu_pkg::OP_BUMP: st_nxt = S_W0;
            wrcu_pkg::OP_CLR: begin
              active_nxt = clamp_n;
              size_nxt   = clamp_n;
              rng_nxt    = cfg.rng_seed;
              tally_nxt  = '0;
              j_nxt      = '0;
              st_nxt     = S_CLR;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cc_we  = 1'b1;
        lst_we = 1'b1;
        slt_we = 1'b1;
        wt_we  = 1'b1;
        sc_we  = 1'b1;
        j_nxt  = j_r + 1'b1;
        if (j_r[IW-1:0] == LAST_IDX) begin
          st_nxt   = init_r ? S_IDLE : S_DONE;
          init_nxt = 1'b0;
        end
      end
      S_A0: begin
        if (j_r >= JW'(active_r)) st_nxt = S_DONE;
        else st_nxt = S_A1;
      end
      S_A1: begin
        lst_ra = size_m1[IW-1:0];
        if (cc_rd == '0) begin
          cc_we = 1'b1;
          cc_wd = COUNT_BITS'(1);
          if (size_r != '0 && slt_rd < size_r) begin
            size_nxt = size_m1;
            p_nxt    = slt_rd;
            st_nxt   = S_A2;
          end else begin
            j_nxt  = j_step;
            st_nxt = S_A0;
          end
        end else begin
          if (cc_rd != CNT_MAX) begin
            cc_we = 1'b1;
            cc_wd = cc_rd + 1'b1;
          end
          j_nxt  = j_step;
          st_nxt = S_A0;
        end
      end
      S_A2: begin
        lst_we = 1'b1;
        lst_wa = p_r[IW-1:0];
        lst_wd = lst_rd;
        slt_we = 1'b1;
        slt_wa = lst_rd;
        slt_wd = p_r;
        j_nxt  = j_step;
        st_nxt = S_A0;
      end
      S_R0: begin
        if (j_r >= JW'(active_r)) st_nxt = S_DONE;
        else st_nxt = S_R1;
      end
      S_R1: begin
        if (cc_rd != '0) begin
          cc_we = 1'b1;
          cc_wd = cc_rd - 1'b1;
          if (cc_rd == COUNT_BITS'(1) && size_r < RING_FULL) begin
            slt_we   = 1'b1;
            slt_wd   = size_r;
            lst_we   = 1'b1;
            lst_wa   = size_r[IW-1:0];
            size_nxt = size_r + 1'b1;
          end
        end
        j_nxt  = j_step;
        st_nxt = S_R0;
      end
      S_B0: begin
        if (i_r >= size_r) st_nxt = S_P;
        else st_nxt = S_B1;
      end
      S_B1: begin
        u_nxt     = lst_rd;
        mod_start = 1'b1;
        mod_dvd   = wrcu_pkg::SEED_W'(lst_rd) << (wrcu_pkg::SEED_W - IW);
        mod_len   = wrcu_pkg::LEN_W'(IW);
        st_nxt    = S_B2;
      end
      S_B2: begin
        if (mod_done) begin
          c_nxt  = mod_rem[IW-1:0];
          st_nxt = S_B3;
        end
      end
      S_B3: st_nxt = S_B4;
      S_B4: begin
        sc_we = 1'b1;
        sc_wa = c_r;
        sc_wd = sum[GW] ? {GW{1'b1}} : sum[GW-1:0];
        if (sc_rd == '0) begin
          tch_we = 1'b1;
          nt_nxt = nt_r + 1'b1;
        end
        i_nxt  = i_r + 1'b1;
        st_nxt = S_B0;
      end
      S_P: begin
        i_nxt = '0;
        if (nt_r == '0) begin
          rng_nxt   = draw;
          mod_start = 1'b1;
          st_nxt    = S_BZ;
        end else if (cfg.noise_threshold != '0) begin
          rng_nxt = draw;
          if (draw[wrcu_pkg::SEED_W-1 -: wrcu_pkg::NOISE_W] < cfg.noise_threshold) begin
            st_nxt = S_N0;
          end else begin
            st_nxt = S_T0;
          end
        end else begin
          st_nxt = S_T0;
        end
      end
      S_BZ: begin
        if (mod_done) begin
          picked_nxt = wrcu_pkg::RES_W'(mod_rem);
          gain_nxt   = '0;
          st_nxt     = S_DONE;
        end
      end
      S_N0: begin
        rng_nxt   = draw;
        mod_start = 1'b1;
        mod_div   = DW'(nt_r);
        st_nxt    = S_N1;
      end
      S_N1: begin
        if (mod_done) begin
          u_nxt  = mod_rem[IW-1:0];
          st_nxt = S_N2;
        end
      end
      S_N2: begin
        tch_ra = u_r;
        st_nxt = S_N3;
      end
      S_N3: begin
        pick_nxt = tch_rd;
        c_nxt    = tch_rd;
        st_nxt   = S_N4;
      end
      S_N4: st_nxt = S_N5;
      S_N5: begin
        gain_nxt   = sc_rd;
        picked_nxt = wrcu_pkg::RES_W'(pick_r);
        st_nxt     = S_K0;
      end
      S_T0: st_nxt = S_T1;
      S_T1: begin
        pick_nxt = tch_rd;
        c_nxt    = tch_rd;
        st_nxt   = S_T2;
      end
      S_T2: st_nxt = S_T3;
      S_T3: begin
        bg_nxt   = sc_rd;
        ties_nxt = SW'(1);
        i_nxt    = SW'(1);
        st_nxt   = S_T4;
      end
      S_T4: begin
        if (i_r >= nt_r) begin
          gain_nxt   = bg_r;
          picked_nxt = wrcu_pkg::RES_W'(pick_r);
          i_nxt      = '0;
          st_nxt     = S_K0;
        end else begin
          st_nxt = S_T5;
        end
      end
      S_T5: begin
        c_nxt  = tch_rd;
        st_nxt = S_T6;
      end
      S_T6: st_nxt = S_T7;
      S_T7: begin
        if (sc_rd > bg_r) begin
          bg_nxt   = sc_rd;
          pick_nxt = c_r;
          ties_nxt = SW'(1);
          i_nxt    = i_r + 1'b1;
          st_nxt   = S_T4;
        end else if (sc_rd == bg_r) begin
          ties_nxt  = ties_inc;
          rng_nxt   = draw;
          mod_start = 1'b1;
          mod_div   = DW'(ties_inc);
          st_nxt    = S_T8;
        end else begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_T4;
        end
      end
      S_T8: begin
        if (mod_done) begin
          if (mod_rem == '0) pick_nxt = c_r;
          i_nxt  = i_r + 1'b1;
          st_nxt = S_T4;
        end
      end
      S_K0: begin
        if (i_r >= nt_r) st_nxt = S_DONE;
        else st_nxt = S_K1;
      end
      S_K1: begin
        sc_we  = 1'b1;
        sc_wa  = tch_rd;
        sc_wd  = '0;
        i_nxt  = i_r + 1'b1;
        st_nxt = S_K0;
      end
      S_W0: begin
        if (i_r >= size_r) st_nxt = S_W4;
        else st_nxt = S_W1;
      end
      S_W1: begin
        u_nxt  = lst_rd;
        st_nxt = S_W2;
      end
      S_W2: st_nxt = S_W3;
      S_W3: begin
        if (wt_rd != WT_MAX) begin
          wt_we = 1'b1;
          wt_wa = u_r;
          wt_wd = wt_rd + 1'b1;
        end
        i_nxt  = i_r + 1'b1;
        st_nxt = S_W0;
      end
      S_W4: begin
        tally_nxt = tally_r + 1'b1;
        if (tally_r == {wrcu_pkg::TALLY_W{1'b1}}) begin
          j_nxt  = '0;
          st_nxt = S_H0;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_H0: begin
        wt_ra = j_r[IW-1:0];
        if (j_r >= JW'(active_r)) st_nxt = S_DONE;
        else st_nxt = S_H1;
      end
      S_H1: begin
        wt_we  = 1'b1;
        wt_wd  = WT_ONE + (wt_rd >> 1);
        j_nxt  = j_r + 1'b1;
        st_nxt = S_H0;
      end
      S_DONE: begin
        if (res_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      init_r   <= 1'b1;
      j_r      <= '0;
      size_r   <= ACTIVE_RST;
      active_r <= ACTIVE_RST;
      rng_r    <= wrcu_pkg::SEED_RST;
      tally_r  <= '0;
      i_r      <= '0;
      nt_r     <= '0;
      ties_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      init_r   <= init_nxt;
      j_r      <= j_nxt;
      size_r   <= size_nxt;
      active_r <= active_nxt;
      rng_r    <= rng_nxt;
      tally_r  <= tally_nxt;
      i_r      <= i_nxt;
      nt_r     <= nt_nxt;
      ties_r   <= ties_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    p_r      <= p_nxt;
    u_r      <= u_nxt;
    c_r      <= c_nxt;
    pick_r   <= pick_nxt;
    bg_r     <= bg_nxt;
    gain_r   <= gain_nxt;
    picked_r <= picked_nxt;
  end

endmodule
`default_nettype wire

// File: design/weighted_residue_cover_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_residue_cover_engine_unit
// Cover engine over a residue ring: class add/remove, best class query with
// noisy pick, weight bumps and clear.
//
//   channel    dir  payload                                      handshake
//   in_chan    in   op, modulus, residue                         valid/ready
//   out_chan   out  picked_residue, best_gain, uncovered_total   valid/ready
//   cfg_chan   in   index, data                                  valid/ready
//
// One item is worked at a time. Add/remove walk the class points one by one;
// a best query reads each uncovered point and takes its class from the
// bit-serial remainder unit, then scans the touched classes, drawing per tie.
// A bump walks the uncovered points; every 2048th also sets weights to 1+w/2.
// Reset and clear run a clearing pass over all RING_MAX entries; no item is
// taken meanwhile. Results wait in an output register.
// ----------------------------------------------------------------------------
module weighted_residue_cover_engine_unit #(
  parameter int RING_MAX    = wrcu_pkg::RING_MAX_DEF,
  parameter int WEIGHT_BITS = wrcu_pkg::WEIGHT_BITS_DEF,
  parameter int COUNT_BITS  = wrcu_pkg::COUNT_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  wrcu_in_if.sink     in_chan,
  wrcu_out_if.source  out_chan,
  wrcu_cfg_if.sink    cfg_chan
);

  wrcu_pkg::cfg_t cfg_r;
  wrcu_pkg::req_t req;
  wrcu_pkg::res_t res;
  logic           req_ready;
  logic           res_ready;
  logic           out_valid_r;
  logic [wrcu_pkg::RES_W-1:0]  out_pick_r;
  logic [wrcu_pkg::GAIN_W-1:0] out_gain_r;
  logic [wrcu_pkg::TOT_W-1:0]  out_tot_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_size       <= wrcu_pkg::RING_RST;
      cfg_r.noise_threshold <= wrcu_pkg::NOISE_RST;
      cfg_r.rng_seed        <= wrcu_pkg::SEED_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        wrcu_pkg::CFG_RING:  cfg_r.ring_size <= cfg_chan.data[wrcu_pkg::RING_W-1:0];
        wrcu_pkg::CFG_NOISE: cfg_r.noise_threshold <= cfg_chan.data[wrcu_pkg::NOISE_W-1:0];
        wrcu_pkg::CFG_SEED:  cfg_r.rng_seed <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign req.op      = in_chan.op;
  assign req.modulus = in_chan.modulus;
  assign req.residue = in_chan.residue;
  assign in_chan.ready = req_ready;

  wrcu_core #(
    .RING_MAX    (RING_MAX),
    .WEIGHT_BITS (WEIGHT_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_chan.valid),
    .req       (req),
    .req_ready (req_ready),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_pick_r <= res.picked_residue;
      out_gain_r <= res.best_gain;
      out_tot_r  <= res.uncovered_total;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.picked_residue  = out_pick_r;
  assign out_chan.best_gain       = out_gain_r;
  assign out_chan.uncovered_total = out_tot_r;

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
      (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("item accepted while another is in progress");
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_chan.valid |-> (32'(out_chan.uncovered_total) <= 32'(RING_MAX)))
    else $error("uncovered count beyond ring");
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
      (res.valid && !res_ready) |=> res.valid)
    else $error("pending result dropped");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted residue cover engine: drives class
// add/remove, best class queries, weight bumps and clears in random bursts,
// tracks ring, weight and generator state in a local model, and compares every
// result item with its predicted value under a stalling receiver.
// ----------------------------------------------------------------------------
module tb;

  localparam int RMAX = wrcu_pkg::RING_MAX_DEF;
  localparam int unsigned CNT_MAX = (1 << wrcu_pkg::COUNT_BITS_DEF) - 1;
  localparam logic [wrcu_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [wrcu_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [wrcu_pkg::RES_W-1:0]  picked_residue;
    logic [wrcu_pkg::GAIN_W-1:0] best_gain;
    logic [wrcu_pkg::TOT_W-1:0]  uncovered_total;
  } cover_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wrcu_in_if  in_if();
  wrcu_out_if out_if();
  wrcu_cfg_if cfg_if();

  weighted_residue_cover_engine_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // engine shadow state
  int unsigned        ring_reg, noise_reg;
  logic [63:0]        seed_reg;
  int unsigned        ring_live, unc_size, bump_count;
  logic [63:0]        xs_state;
  int unsigned        cover_cnt[RMAX];
  int unsigned        unc_list[RMAX];
  int unsigned        unc_slot[RMAX];
  int unsigned        weight[RMAX];
  int unsigned        class_sum[RMAX];
  int unsigned        touched[RMAX];

  wrcu_pkg::req_t     pending_items[$];
  cover_result_t      expected_results[$];
  wrcu_pkg::req_t     cur_item;
  int unsigned        burst_left, gap_left;
  int unsigned        mismatches;
  int unsigned        rx_cycle;

  function automatic logic [63:0] next_draw();
    logic [63:0] x;
    x = xs_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    xs_state = x;
    return x;
  endfunction

  function automatic void clear_ring();
    ring_live = (ring_reg == 0) ? 1 : (ring_reg > RMAX ? RMAX : ring_reg);
    for (int j = 0; j < RMAX; j++) begin
      cover_cnt[j] = 0;
      unc_list[j] = j;
      unc_slot[j] = j;
      weight[j] = 1;
      class_sum[j] = 0;
      touched[j] = 0;
    end
    unc_size = ring_live;
    xs_state = seed_reg;
    bump_count = 0;
  endfunction

  function automatic void drop_point(int unsigned j);
    int unsigned p, last;
    p = unc_slot[j];
    if (unc_size == 0 || p >= unc_size) return;
    unc_size--;
    last = unc_list[unc_size];
    unc_list[p] = last;
    if (last < RMAX) unc_slot[last] = p;
  endfunction

  function automatic void restore_point(int unsigned j);
    if (unc_size >= RMAX) return;
    unc_slot[j] = unc_size;
    unc_list[unc_size] = j;
    unc_size++;
  endfunction

  function automatic void pick_best(input int unsigned m, output int unsigned pick,
                                    output int unsigned gain);
    int unsigned nt, u, c, bg, ties;
    longint unsigned s;
    nt = 0;
    for (int i = 0; i < unc_size && i < RMAX; i++) begin
      u = unc_list[i];
      c = u % m;
      if (class_sum[c] == 0) begin
        touched[nt] = c;
        nt++;
      end
      s = longint'(class_sum[c]) + longint'(weight[u]);
      class_sum[c] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(s);
    end
    if (nt == 0) begin
      gain = 0;
      pick = next_draw() % m;
      return;
    end
    if (noise_reg > 0 && (next_draw() >> 48) < noise_reg) begin
      pick = touched[next_draw() % nt];
      gain = class_sum[pick];
    end else begin
      bg = class_sum[touched[0]];
      ties = 1;
      pick = touched[0];
      for (int i = 1; i < nt; i++) begin
        c = touched[i];
        if (class_sum[c] > bg) begin
          bg = class_sum[c];
          pick = c;
          ties = 1;
        end else if (class_sum[c] == bg) begin
          ties++;
          if (next_draw() % ties == 0) pick = c;
        end
      end
      gain = bg;
    end
    for (int i = 0; i < nt; i++) class_sum[touched[i]] = 0;
  endfunction

  function automatic cover_result_t predict_cover(wrcu_pkg::req_t it);
    cover_result_t r;
    int unsigned m, pick, gain;
    m = it.modulus;
    pick = 0;
    gain = 0;
    case (it.op)
      wrcu_pkg::OP_ADD: begin
        if (m != 0)
          for (int unsigned j = it.residue; j < ring_live; j += m) begin
            if (cover_cnt[j] == 0) begin
              cover_cnt[j] = 1;
              drop_point(j);
            end else if (cover_cnt[j] < CNT_MAX) begin
              cover_cnt[j]++;
            end
          end
      end
      wrcu_pkg::OP_REM: begin
        if (m != 0)
          for (int unsigned j = it.residue; j < ring_live; j += m) begin
            if (cover_cnt[j] != 0) begin
              cover_cnt[j]--;
              if (cover_cnt[j] == 0) restore_point(j);
            end
          end
      end
      wrcu_pkg::OP_BEST: begin
        if (m != 0) pick_best(m, pick, gain);
      end
      wrcu_pkg::OP_BUMP: begin
        for (int q = 0; q < unc_size && q < RMAX; q++)
          if (weight[unc_list[q]] != 32'hFFFF_FFFF) weight[unc_list[q]]++;
        bump_count = (bump_count + 1) & 2047;
        if (bump_count == 0)
          for (int j = 0; j < ring_live; j++) weight[j] = 1 + weight[j] / 2;
      end
      wrcu_pkg::OP_CLR: clear_ring();
      default: ;
    endcase
    r.picked_residue = pick[wrcu_pkg::RES_W-1:0];
    r.best_gain = gain;
    r.uncovered_total = unc_size[wrcu_pkg::TOT_W-1:0];
    return r;
  endfunction

  // input driver: bursts with random gaps
  always @(posedge clk) begin
    logic nv;
    wrcu_pkg::req_t ni;
    nv = in_if.valid;
    ni = cur_item;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(predict_cover(cur_item));
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          ni = pending_items.pop_front();
          nv = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
          end
        end
      end
    end
    cur_item = ni;
    in_if.valid <= nv;
    in_if.op <= ni.op;
    in_if.modulus <= ni.modulus;
    in_if.residue <= ni.residue;
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin
    cover_result_t e;
    logic rdy;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result res=%0d gain=%0d tot=%0d",
                   out_if.picked_residue, out_if.best_gain, out_if.uncovered_total);
      end else begin
        e = expected_results.pop_front();
        if (out_if.picked_residue !== e.picked_residue || out_if.best_gain !== e.best_gain ||
            out_if.uncovered_total !== e.uncovered_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp res=%0d gain=%0d tot=%0d got res=%0d gain=%0d tot=%0d",
                     e.picked_residue, e.best_gain, e.uncovered_total, out_if.picked_residue,
                     out_if.best_gain, out_if.uncovered_total);
        end
      end
    end
    rx_cycle++;
    case ((rx_cycle / 3000) % 3)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      default: rdy = (rx_cycle % 7) > 2;
    endcase
    out_if.ready <= rdy;
  end

  function automatic wrcu_pkg::req_t mk(logic [wrcu_pkg::OP_W-1:0] op, int unsigned m,
                                        int unsigned r);
    wrcu_pkg::req_t it;
    it.op = op;
    it.modulus = m[wrcu_pkg::MOD_W-1:0];
    it.residue = r[wrcu_pkg::RES_W-1:0];
    return it;
  endfunction

  function automatic wrcu_pkg::req_t rand_item(int unsigned ring, int unsigned mod_cap);
    int unsigned k, m, r;
    logic [wrcu_pkg::OP_W-1:0] op;
    k = $urandom_range(0, 99);
    if (k < 32) op = wrcu_pkg::OP_ADD;
    else if (k < 52) op = wrcu_pkg::OP_REM;
    else if (k < 82) op = wrcu_pkg::OP_BEST;
    else if (k < 95) op = wrcu_pkg::OP_BUMP;
    else if (k < 97) op = wrcu_pkg::OP_CLR;
    else op = wrcu_pkg::OP_W'(OP_SPARE_LO + $urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
    k = $urandom_range(0, 19);
    if (k == 0) m = 0;
    else if (k == 1) m = $urandom_range(0, 8191);
    else m = $urandom_range(1, mod_cap);
    if (m != 0 && $urandom_range(0, 9) != 0) r = $urandom_range(0, m - 1);
    else r = $urandom_range(0, 4095);
    return mk(op, m, r);
  endfunction

  task automatic cfg_write(logic [wrcu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      wrcu_pkg::CFG_RING:  ring_reg = 32'(val[wrcu_pkg::RING_W-1:0]);
      wrcu_pkg::CFG_NOISE: noise_reg = 32'(val[wrcu_pkg::NOISE_W-1:0]);
      wrcu_pkg::CFG_SEED:  seed_reg = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_phase(int unsigned ring, int unsigned noise, logic [63:0] seed);
    drain();
    cfg_write(wrcu_pkg::CFG_RING, 64'(ring));
    cfg_write(wrcu_pkg::CFG_NOISE, 64'(noise));
    cfg_write(wrcu_pkg::CFG_SEED, seed);
    pending_items.push_back(mk(wrcu_pkg::OP_CLR, 0, 0));
  endtask

  initial begin
    int unsigned ring;
    in_if.valid = 1'b0;
    in_if.op = wrcu_pkg::OP_ADD;
    in_if.modulus = '0;
    in_if.residue = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = wrcu_pkg::CFG_RING;
    cfg_if.data = '0;
    cur_item = mk(wrcu_pkg::OP_ADD, 0, 0);
    burst_left = 0;
    gap_left = 0;
    mismatches = 0;
    rx_cycle = 0;
    ring_reg = 32'(wrcu_pkg::RING_RST);
    noise_reg = 32'(wrcu_pkg::NOISE_RST);
    seed_reg = wrcu_pkg::SEED_RST;
    clear_ring();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // full ring at reset settings
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BUMP, 0, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 2, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 3, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_REM, 2, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 0, 4095));
    pending_items.push_back(mk(OP_SPARE_LO, 8191, 4095));
    pending_items.push_back(mk(OP_SPARE_HI, 1, 0));

    // oversize ring, always noisy, generator stuck at zero
    set_phase(8191, 65535, 64'd0);
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 2, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 4096, 4095));
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 8191, 4095));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 5, 0));

    // zero ring, no noise: stacked covers and empty queries
    set_phase(0, 0, 64'd1);
    for (int i = 0; i < 4; i++) pending_items.push_back(mk(wrcu_pkg::OP_ADD, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_REM, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 4096, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 3, 5));
    for (int i = 0; i < 4; i++) pending_items.push_back(mk(wrcu_pkg::OP_REM, 1, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_REM, 1, 0));

    // tiny ring with weight bumps
    set_phase(3, wrcu_pkg::NOISE_RST, {$urandom, $urandom} | 64'd1);
    pending_items.push_back(mk(wrcu_pkg::OP_ADD, 3, 2));
    for (int i = 0; i < 6; i++) pending_items.push_back(mk(wrcu_pkg::OP_BUMP, 0, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 2, 0));
    pending_items.push_back(mk(wrcu_pkg::OP_BEST, 1, 0));

    // random phases on small rings
    for (int p = 0; p < 4; p++) begin
      ring = $urandom_range(8, 200);
      set_phase(ring, (p == 0) ? 0 : (p == 1) ? 65535 : $urandom_range(0, 65535),
                {$urandom, $urandom} | 64'd1);
      for (int i = 0; i < 14; i++) pending_items.push_back(rand_item(ring, ring));
    end

    // a few items on the full ring, moduli mostly capped at 8
    set_phase(4096, $urandom_range(0, 65535), {$urandom, $urandom} | 64'd1);
    for (int i = 0; i < 6; i++) pending_items.push_back(rand_item(4096, 8));

    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
